[sv/varint_varlong_codec_core_defines.svh]
// Assertion macros shared by the varint/varlong codec RTL.
// No dependencies; included by modules that carry assertions.
`ifndef VARINT_VARLONG_CODEC_CORE_DEFINES_SVH
`define VARINT_VARLONG_CODEC_CORE_DEFINES_SVH

`ifndef SYNTH

// Property must hold at every clock edge outside reset.
`define VVC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("vvc assertion failed");

// Condition must never be seen outside reset.
`define VVC_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("vvc forbidden condition seen");

`else

`define VVC_ASSERT(lbl, clk, rst, prop)
`define VVC_NEVER(lbl, clk, rst, cond)

`endif

`endif

[sv/vvc_pkg.sv]
// Types and constants for the varint/varlong codec.
// No dependencies; used by every module of the codec.
`timescale 1ns / 1ps
`default_nettype none

package vvc_pkg;

   localparam int GROUP_BITS  = 7;
   localparam int NUM_GROUPS  = 10;
   localparam int SHORT_LIMIT = 5;
   localparam int LONG_LIMIT  = 10;

   localparam logic CMD_DECODE = 1'b0;
   localparam logic CMD_ENCODE = 1'b1;

   localparam logic [1:0] KIND_VALUE    = 2'd0;
   localparam logic [1:0] KIND_BYTE     = 2'd1;
   localparam logic [1:0] KIND_TOO_BIG  = 2'd2;
   localparam logic [1:0] KIND_DEPLETED = 2'd3;

   typedef logic [3:0] count_type;

   // decoder result toward the output register
   typedef struct packed {
      logic        fire;
      logic [1:0]  kind;
      logic [63:0] value;
   } dec_res_type;

   // one encoded digit from the encode shifter
   typedef struct packed {
      logic       active;
      logic [7:0] data;
      logic       last;
   } enc_digit_type;

endpackage

`default_nettype wire

[sv/vvc_dec_acc.sv]
// Decode accumulator: packs up to ten 7-bit groups into 64 bits.
// Depends on vvc_pkg and the codec assertion macros.
`timescale 1ns / 1ps
`default_nettype none
`include "varint_varlong_codec_core_defines.svh"

module vvc_dec_acc (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  strobe,
   input  wire                  long_form,
   input  wire  [7:0]           in_byte,
   input  wire                  byte_is_last,
   output vvc_pkg::dec_res_type res
);

   logic [63:0]        acc_ff, acc_in;
   vvc_pkg::count_type count_ff, count_in;

   logic [63:0] add;
   logic [63:0] merged;
   logic        cont;
   logic        too_big;
   logic        depleted;

   always_comb begin
      add = '0;
      for (int i = 0; i < vvc_pkg::NUM_GROUPS; i++) begin
         if (count_ff == 4'(i)) begin
            add = add | (64'(in_byte[6:0]) << (i * vvc_pkg::GROUP_BITS));
         end
      end
      // short form keeps only what lands below bit 32
      if (!long_form) begin
         add = add & 64'h0000_0000_FFFF_FFFF;
      end
   end

   assign cont   = in_byte[7];
   assign merged = acc_ff | add;

   always_comb begin
      if (long_form) begin
         too_big = cont && (count_ff >= 4'(vvc_pkg::LONG_LIMIT - 1));
      end else begin
         too_big = cont && (count_ff >= 4'(vvc_pkg::SHORT_LIMIT - 1));
      end
   end

   assign depleted = cont && byte_is_last && !too_big;

   always_comb begin
      acc_in    = acc_ff;
      count_in  = count_ff;
      res.fire  = 1'b0;
      res.kind  = vvc_pkg::KIND_VALUE;
      res.value = '0;
      if (strobe) begin
         if (too_big) begin
            acc_in   = '0;
            count_in = '0;
            res.fire = 1'b1;
            res.kind = vvc_pkg::KIND_TOO_BIG;
         end else if (depleted) begin
            acc_in   = '0;
            count_in = '0;
            res.fire = 1'b1;
            res.kind = vvc_pkg::KIND_DEPLETED;
         end else if (cont) begin
            acc_in   = merged;
            count_in = count_ff + 4'd1;
         end else begin
            acc_in   = '0;
            count_in = '0;
            res.fire = 1'b1;
            res.kind = vvc_pkg::KIND_VALUE;
            if (long_form) begin
               res.value = merged;
            end else begin
               res.value = {{32{merged[31]}}, merged[31:0]};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         count_ff <= '0;
      end else begin
         acc_ff   <= acc_in;
         count_ff <= count_in;
      end
   end

   `VVC_ASSERT(a_count_range, clock, reset, count_ff <= 4'(vvc_pkg::LONG_LIMIT - 1))
   `VVC_ASSERT(a_fire_clears, clock, reset, res.fire |=> (count_ff == '0 && acc_ff == '0))
   `VVC_NEVER(a_err_value, clock, reset, res.fire && res.kind != vvc_pkg::KIND_VALUE && res.value != '0)

endmodule

`default_nettype wire

[sv/vvc_enc_ser.sv]
// Encode shifter: one 7-bit group per advance cycle, low first.
// Depends on vvc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vvc_enc_ser (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    load,
   input  wire                    long_form,
   input  wire  [63:0]            plain_value,
   input  wire                    advance,
   output vvc_pkg::enc_digit_type digit
);

   logic [63:0] shift_ff, shift_in;
   logic        active_ff, active_in;
   logic        rest_zero;

   assign rest_zero = (shift_ff[63:vvc_pkg::GROUP_BITS] == '0);

   assign digit.active = active_ff;
   assign digit.last   = rest_zero;
   assign digit.data   = {!rest_zero, shift_ff[vvc_pkg::GROUP_BITS-1:0]};

   always_comb begin
      shift_in  = shift_ff;
      active_in = active_ff;
      if (load) begin
         shift_in  = long_form ? plain_value : {32'b0, plain_value[31:0]};
         active_in = 1'b1;
      end else if (active_ff && advance) begin
         shift_in = shift_ff >> vvc_pkg::GROUP_BITS;
         // drop out after the final group
         if (rest_zero) begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
      shift_ff <= shift_in;
   end

endmodule

`default_nettype wire

[sv/varint_varlong_codec_core.sv]
// Top level of the LEB128-style varint/varlong codec: request handshake, output register.
// Depends on vvc_pkg, vvc_dec_acc, vvc_enc_ser and the codec assertion macros.
//
//   channel  direction  handshake           contents
//   req_     in         req_valid/req_stall command, form, byte, last flag, value
//   rsp_     out        rsp_valid/rsp_stall kind, decoded value, byte, last flag
//
// Decode takes a byte per unstalled cycle; the output register holds its result next cycle.
// Encode loads the shift register; it emits one 7-bit group per cycle while output is free.
// Requests stall while an encode is shifting out or the output register is held.
// Synchronous reset clears the decode accumulator, group count and valid flags.
`timescale 1ns / 1ps
`default_nettype none
`include "varint_varlong_codec_core_defines.svh"

module varint_varlong_codec_core (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  wire               req_command,
   input  wire               req_long_form,
   input  wire        [7:0]  req_in_byte,
   input  wire               req_byte_is_last,
   input  wire signed [63:0] req_plain_value,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output logic       [1:0]  rsp_kind,
   output logic signed [63:0] rsp_decoded_value,
   output logic       [7:0]  rsp_out_byte,
   output logic              rsp_last
);

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_kind_ff, rsp_kind_in;
   logic [63:0] rsp_value_ff, rsp_value_in;
   logic [7:0]  rsp_byte_ff, rsp_byte_in;
   logic        rsp_last_ff, rsp_last_in;

   logic                   out_free;
   logic                   req_accept;
   logic                   dec_strobe;
   logic                   enc_load;
   logic                   enc_advance;
   vvc_pkg::dec_res_type   dec_res;
   vvc_pkg::enc_digit_type enc_digit;

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign req_stall   = enc_digit.active || !out_free;
   assign req_accept  = req_valid && !req_stall;
   assign dec_strobe  = req_accept && (req_command == vvc_pkg::CMD_DECODE);
   assign enc_load    = req_accept && (req_command == vvc_pkg::CMD_ENCODE);
   assign enc_advance = enc_digit.active && out_free;

   vvc_dec_acc u_dec (
      .clock        (clock),
      .reset        (reset),
      .strobe       (dec_strobe),
      .long_form    (req_long_form),
      .in_byte      (req_in_byte),
      .byte_is_last (req_byte_is_last),
      .res          (dec_res)
   );

   vvc_enc_ser u_enc (
      .clock       (clock),
      .reset       (reset),
      .load        (enc_load),
      .long_form   (req_long_form),
      .plain_value (req_plain_value),
      .advance     (enc_advance),
      .digit       (enc_digit)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_value_in = rsp_value_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (out_free) begin
         rsp_valid_in = 1'b0;
      end
      if (dec_res.fire) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = dec_res.kind;
         rsp_value_in = dec_res.value;
         rsp_byte_in  = '0;
         rsp_last_in  = 1'b1;
      end else if (enc_advance) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = vvc_pkg::KIND_BYTE;
         rsp_value_in = '0;
         rsp_byte_in  = enc_digit.data;
         rsp_last_in  = enc_digit.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_kind_ff  <= rsp_kind_in;
      rsp_value_ff <= rsp_value_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_decoded_value = rsp_value_ff;
   assign rsp_out_byte      = rsp_byte_ff;
   assign rsp_last          = rsp_last_ff;

   `VVC_ASSERT(a_enc_blocks_req, clock, reset, enc_digit.active |-> req_stall)
   `VVC_ASSERT(a_enc_ends_last, clock, reset, ($fell(enc_digit.active) && !$past(reset)) |-> (rsp_valid && rsp_last && rsp_kind == vvc_pkg::KIND_BYTE))
   `VVC_NEVER(a_single_last, clock, reset, rsp_valid && rsp_kind != vvc_pkg::KIND_BYTE && !rsp_last)
   `VVC_NEVER(a_one_source, clock, reset, dec_res.fire && enc_advance)

endmodule

`default_nettype wire
